// ===== rtl/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// isp_pkg: shared definitions for the incremental speed PID
// Field widths, configuration register indexes, reset values and the PWM cap.
// ----------------------------------------------------------------------------
`default_nettype none

package isp_pkg;

  // Field widths
  localparam int SAMPLE_W    = 15;
  localparam int GAIN_W      = 16;
  localparam int DIFF_W      = 18;
  localparam int TERM_W      = 16;
  localparam int LIMIT_W     = 15;
  localparam int DRIVE_W     = 15;
  localparam int DUTY_W      = 13;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 4;

  // Duty cycle ceiling of the PWM channel
  localparam logic [DRIVE_W-1:0] PWM_CAP = 15'd5000;

  // Register reset values
  localparam logic [LIMIT_W-1:0]         TERM_LIMIT_RST = 15'd32767;
  localparam logic signed [GAIN_W-1:0]   STEP_MAX_RST   = 16'sh7FFF;
  localparam logic signed [GAIN_W-1:0]   STEP_MIN_RST   = 16'sh8000;
  localparam logic [DRIVE_W-1:0]         OUT_MAX_RST    = 15'd5000;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GAIN_PROP        = 4'd0,
    REG_GAIN_FIRST_DIFF  = 4'd1,
    REG_GAIN_SECOND_DIFF = 4'd2,
    REG_TARGET_SPEED     = 4'd3,
    REG_TERM_LIMIT       = 4'd4,
    REG_STEP_MAX         = 4'd5,
    REG_STEP_MIN         = 4'd6,
    REG_OUT_MAX          = 4'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/isp_term.sv =====
// ----------------------------------------------------------------------------
// isp_term: one clamped controller term
// Multiplies a Q8.8 gain by a difference, truncates toward zero and
// saturates the result to plus or minus the term limit.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_term (
  input  wire logic signed [isp_pkg::GAIN_W-1:0]  gain,
  input  wire logic signed [isp_pkg::DIFF_W-1:0]  diff,
  input  wire logic        [isp_pkg::LIMIT_W-1:0] limit,
  output      logic signed [isp_pkg::TERM_W-1:0]  term
);
  import isp_pkg::*;

  localparam int PROD_W = GAIN_W + DIFF_W;
  localparam int Q_W    = PROD_W - 8;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;
  logic signed [Q_W-1:0]    quot;
  logic signed [Q_W-1:0]    lim_pos;
  logic signed [Q_W-1:0]    lim_neg;

  // Full product, then round toward zero on the divide by 256
  assign prod    = gain * diff;
  assign biased  = prod[PROD_W-1] ? prod + PROD_W'(255) : prod;
  assign quot    = biased[PROD_W-1:8];

  // Saturate to the symmetric limit
  assign lim_pos = $signed({{(Q_W-LIMIT_W){1'b0}}, limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (quot > lim_pos) begin
      term = lim_pos[TERM_W-1:0];
    end else if (quot < lim_neg) begin
      term = lim_neg[TERM_W-1:0];
    end else begin
      term = quot[TERM_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/incremental_speed_pid.sv =====
// ----------------------------------------------------------------------------
// incremental_speed_pid: incremental PID speed controller
// Turns one encoder speed sample per tick into a clamped drive value and a
// PWM duty, keeping the last two samples and the last drive.
// ----------------------------------------------------------------------------
// Pipeline: a sample passes through the difference register, the step register
//   and the drive register, in that order, before its result is valid.
// Throughput: one sample per cycle while result_stall is low; the drive register closes the only loop.
// Reset: rst clears the pipeline, the sample history, the drive and the
//   configuration registers (limits to their full range, drive cap 5000).
`default_nettype none

module incremental_speed_pid (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_write,
  input  wire logic [isp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [isp_pkg::CFG_DATA_W-1:0]    cfg_data,
  // sample channel
  input  wire logic                              sample_valid,
  output      logic                              sample_stall,
  input  wire logic [isp_pkg::SAMPLE_W-1:0]      encoder_count,
  // result channel
  output      logic                              result_valid,
  input  wire logic                              result_stall,
  output      logic [isp_pkg::DRIVE_W-1:0]       drive_value,
  output      logic [isp_pkg::DUTY_W-1:0]        pwm_duty
);
  import isp_pkg::*;

  // Configuration registers
  logic signed [GAIN_W-1:0]  gain_prop;
  logic signed [GAIN_W-1:0]  gain_first_diff;
  logic signed [GAIN_W-1:0]  gain_second_diff;
  logic signed [GAIN_W-1:0]  target_speed;
  logic        [LIMIT_W-1:0] term_limit;
  logic signed [GAIN_W-1:0]  step_max;
  logic signed [GAIN_W-1:0]  step_min;
  logic        [DRIVE_W-1:0] out_max;

  // Sample history
  logic [SAMPLE_W-1:0] prev_sample;
  logic [SAMPLE_W-1:0] prev_prev_sample;

  // Difference stage
  logic                     diff_valid;
  logic signed [DIFF_W-1:0] err_diff;
  logic signed [DIFF_W-1:0] first_diff;
  logic signed [DIFF_W-1:0] second_diff;

  // Step stage
  logic                     step_valid;
  logic signed [TERM_W-1:0] step;

  // Handshake
  logic sample_take;
  logic out_free;
  logic step_free;
  logic diff_free;
  logic step_move;
  logic diff_move;

  // Combinational values
  logic signed [DIFF_W-1:0] err_diff_next;
  logic signed [DIFF_W-1:0] first_diff_next;
  logic signed [DIFF_W-1:0] second_diff_next;
  logic signed [TERM_W-1:0] term_p;
  logic signed [TERM_W-1:0] term_i;
  logic signed [TERM_W-1:0] term_d;
  logic signed [DIFF_W-1:0] step_sum;
  logic signed [DIFF_W-1:0] step_hi;
  logic signed [DIFF_W-1:0] step_lo;
  logic signed [TERM_W-1:0] step_next;
  logic signed [DRIVE_W+1:0] drive_sum;
  logic signed [DRIVE_W+1:0] drive_cap;
  logic [DRIVE_W-1:0]       drive_next;
  logic [DRIVE_W-1:0]       duty_wide;

  // Advance a stage when the next one is empty or moving on
  assign out_free     = !result_valid || !result_stall;
  assign step_free    = !step_valid || out_free;
  assign diff_free    = !diff_valid || step_free;
  assign step_move    = step_valid && out_free;
  assign diff_move    = diff_valid && step_free;
  assign sample_stall = !diff_free;
  assign sample_take  = sample_valid && diff_free;

  // Configuration decode
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop        <= '0;
      gain_first_diff  <= '0;
      gain_second_diff <= '0;
      target_speed     <= '0;
      term_limit       <= TERM_LIMIT_RST;
      step_max         <= STEP_MAX_RST;
      step_min         <= STEP_MIN_RST;
      out_max          <= OUT_MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN_PROP:        gain_prop        <= $signed(cfg_data);
        REG_GAIN_FIRST_DIFF:  gain_first_diff  <= $signed(cfg_data);
        REG_GAIN_SECOND_DIFF: gain_second_diff <= $signed(cfg_data);
        REG_TARGET_SPEED:     target_speed     <= $signed(cfg_data);
        REG_TERM_LIMIT:       term_limit       <= cfg_data[LIMIT_W-1:0];
        REG_STEP_MAX:         step_max         <= $signed(cfg_data);
        REG_STEP_MIN:         step_min         <= $signed(cfg_data);
        REG_OUT_MAX:          out_max          <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Form error and sample differences from the incoming transaction
  assign err_diff_next    = $signed({{(DIFF_W-GAIN_W){target_speed[GAIN_W-1]}}, target_speed})
                          - $signed({{(DIFF_W-SAMPLE_W){1'b0}}, encoder_count});
  assign first_diff_next  = $signed({{(DIFF_W-SAMPLE_W){1'b0}}, encoder_count})
                          - $signed({{(DIFF_W-SAMPLE_W){1'b0}}, prev_sample});
  assign second_diff_next = $signed({{(DIFF_W-SAMPLE_W){1'b0}}, prev_prev_sample})
                          + $signed({{(DIFF_W-SAMPLE_W){1'b0}}, encoder_count})
                          - $signed({{(DIFF_W-SAMPLE_W-1){1'b0}}, prev_sample, 1'b0});

  // Capture differences and shift the sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid       <= 1'b0;
      prev_sample      <= '0;
      prev_prev_sample <= '0;
    end else begin
      if (sample_take) begin
        diff_valid       <= 1'b1;
        prev_sample      <= encoder_count;
        prev_prev_sample <= prev_sample;
      end else if (diff_move) begin
        diff_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      err_diff    <= err_diff_next;
      first_diff  <= first_diff_next;
      second_diff <= second_diff_next;
    end
  end

  // Three scaled and saturated terms
  isp_term u_term_p (
    .gain  (gain_prop),
    .diff  (err_diff),
    .limit (term_limit),
    .term  (term_p)
  );

  isp_term u_term_i (
    .gain  (gain_first_diff),
    .diff  (first_diff),
    .limit (term_limit),
    .term  (term_i)
  );

  isp_term u_term_d (
    .gain  (gain_second_diff),
    .diff  (second_diff),
    .limit (term_limit),
    .term  (term_d)
  );

  // Combine terms and clamp the increment, upper bound checked first
  assign step_sum = DIFF_W'(term_d) - DIFF_W'(term_i) + DIFF_W'(term_p);
  assign step_hi  = DIFF_W'(step_max);
  assign step_lo  = DIFF_W'(step_min);

  always_comb begin
    if (step_sum > step_hi) begin
      step_next = step_max;
    end else if (step_sum < step_lo) begin
      step_next = step_min;
    end else begin
      step_next = step_sum[TERM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else if (diff_move) begin
      step_valid <= 1'b1;
    end else if (step_move) begin
      step_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (diff_move) begin
      step <= step_next;
    end
  end

  // Accumulate onto the previous drive and clamp to 0..out_max
  assign drive_sum = $signed({2'b00, drive_value}) + (DRIVE_W+2)'(step);
  assign drive_cap = $signed({2'b00, out_max});

  always_comb begin
    if (drive_sum < 0) begin
      drive_next = '0;
    end else if (drive_sum > drive_cap) begin
      drive_next = out_max;
    end else begin
      drive_next = drive_sum[DRIVE_W-1:0];
    end
  end

  // Drive register doubles as the stored previous drive
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      drive_value  <= '0;
    end else begin
      if (step_move) begin
        result_valid <= 1'b1;
        drive_value  <= drive_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Cap the duty at the PWM limit
  assign duty_wide = (drive_value > PWM_CAP) ? PWM_CAP : drive_value;
  assign pwm_duty  = duty_wide[DUTY_W-1:0];

  // Checks
  a_drive_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> drive_value <= out_max)
    else $error("drive value above out_max");

  a_duty_cap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pwm_duty <= PWM_CAP[DUTY_W-1:0])
                     && ((drive_value > PWM_CAP) || (DRIVE_W'(pwm_duty) == drive_value)))
    else $error("pwm duty does not follow drive value");

  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    (step_valid && (step_max >= step_min)) |-> (step <= step_max) && (step >= step_min))
    else $error("increment outside step clamps");

  a_step_not_lost: assert property (@(posedge clk) disable iff (rst)
    step_valid |=> (step_valid || result_valid))
    else $error("increment dropped between stages");

endmodule

`default_nettype wire
